FILE: rtl/core/md5_pkg.sv
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_RND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic       FUNC_ABSORB = 1'b0;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'h3f;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [3:0] LAST_WORD  = 4'd15;
  localparam logic [1:0] LAST_IDX   = 2'd3;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROUND_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic       init;
    logic       load;
    logic       sum_en;
    logic       step_en;
    logic       fold;
    logic [5:0] rnd;
  } rnd_ctrl_t;

  typedef struct packed {
    logic       byte_we;
    logic       pad_we;
    logic       second;
    logic [3:0] pad_addr;
    logic [5:0] rnd;
  } buf_ctrl_t;

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    return lo;
      2'd1:    return 4'(lo * 4'd5 + 4'd1);
      2'd2:    return 4'(lo * 4'd3 + 4'd5);
      default: return 4'(lo * 4'd7);
    endcase
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    case (grp)
      2'd0:    return d ^ (b & (c ^ d));
      2'd1:    return c ^ (d & (b ^ c));
      2'd2:    return b ^ c ^ d;
      default: return c ^ (b | ~d);
    endcase
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

FILE: rtl/core/md5_msg_buf.sv
module md5_msg_buf (
  input  logic                 clk,
  input  md5_pkg::buf_ctrl_t   ctrl,
  input  logic [5:0]           pos,
  input  logic [7:0]           data_byte,
  input  logic [63:0]          bit_len,
  output logic [31:0]          rd_word
);

  logic [3:0][7:0] mem_r [16];
  logic [31:0]     rd_word_r;
  logic [3:0]      lane_we;
  logic [3:0][7:0] lane_data;
  logic [31:0]     len_word;
  logic            len_zone;
  logic [5:0]      idx [4];

  assign len_word = ctrl.pad_addr[0] ? bit_len[63:32] : bit_len[31:0];
  assign len_zone = (ctrl.pad_addr[3:1] == 3'b111);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      idx[j] = {ctrl.pad_addr, 2'(j)};
      if (ctrl.second) begin
        lane_we[j]   = 1'b1;
        lane_data[j] = len_zone ? len_word[8*j +: 8] : 8'h00;
      end else if (idx[j] < pos) begin
        lane_we[j]   = 1'b0;
        lane_data[j] = 8'h00;
      end else if (idx[j] == pos) begin
        lane_we[j]   = 1'b1;
        lane_data[j] = md5_pkg::PAD_BYTE;
      end else begin
        lane_we[j]   = 1'b1;
        lane_data[j] = (len_zone && pos < md5_pkg::LEN_POS) ? len_word[8*j +: 8] : 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.byte_we) begin
      mem_r[pos[5:2]][pos[1:0]] <= data_byte;
    end else if (ctrl.pad_we) begin
      for (int j = 0; j < 4; j++) begin
        if (lane_we[j]) begin
          mem_r[ctrl.pad_addr][j] <= lane_data[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_word_r <= mem_r[md5_pkg::msg_index(ctrl.rnd)];
  end

  assign rd_word = rd_word_r;

endmodule

FILE: rtl/core/md5_round_unit.sv
module md5_round_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  md5_pkg::rnd_ctrl_t   ctrl,
  input  logic [31:0]          msg_word,
  output logic [3:0][31:0]     chain
);

  logic [3:0][31:0] chain_r;
  logic [31:0]      a_r, b_r, c_r, d_r, sum_r;
  logic [31:0]      f_val;
  logic [4:0]       s_amt;

  assign f_val = md5_pkg::round_f(ctrl.rnd[5:4], b_r, c_r, d_r);
  assign s_amt = md5_pkg::ROUND_S[{ctrl.rnd[5:4], ctrl.rnd[1:0]}];

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      chain_r[0] <= md5_pkg::INIT_A;
      chain_r[1] <= md5_pkg::INIT_B;
      chain_r[2] <= md5_pkg::INIT_C;
      chain_r[3] <= md5_pkg::INIT_D;
    end else if (ctrl.fold) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (ctrl.sum_en) begin
      sum_r <= a_r + md5_pkg::ROUND_K[ctrl.rnd] + msg_word;
    end else if (ctrl.step_en) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + md5_pkg::rotl32(sum_r + f_val, s_amt);
    end
  end

  assign chain = chain_r;

endmodule

FILE: rtl/core/md5_digest_engine.sv
// MD5 digest engine over a byte stream.
// Input channel (in_valid/in_ready): one beat carries in_func and in_data_byte.
//   in_func = 0 absorbs in_data_byte; in_func = 1 finalizes the message.
// Output channel (out_valid/out_ready): four beats per finalize, digest words
//   A, B, C, D with out_word_index 0..3 and out_last_word on D.
// Absorb: each beat is taken while the engine idles, except that the beat that fills the
//   64-byte block then holds in_ready low while the block
//   is compressed (a load step, 64 rounds of two phases each, sum then
//   step, then a fold step).
// Finalize: the 16 block words are padded, then one compression runs; with
//   56 or more bytes pending a second padded block follows. The digest
//   beats then go out one per cycle while out_ready is high.
// Stall: out_valid and the digest beat hold until out_ready; no input is
//   taken while digest beats are pending. After the last beat the chaining
//   words and byte count return to their initial values.
// Reset (rst_n low, synchronous): engine idles with initial chaining words
//   and a zero byte count; block buffer contents are left as they are.
module md5_digest_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  md5_pkg::state_t    state_r, state_nxt;
  logic               fin_r, fin_nxt;
  logic               spill_r, spill_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [5:0]         rnd_r, rnd_nxt;
  logic               ph_r, ph_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [60:0]        total_r, total_nxt;
  logic [5:0]         pos;
  logic [31:0]        msg_word;
  logic [3:0][31:0]   chain;
  md5_pkg::rnd_ctrl_t rc;
  md5_pkg::buf_ctrl_t bc;

  assign pos = total_r[5:0];

  md5_msg_buf u_buf (
    .clk       (clk),
    .ctrl      (bc),
    .pos       (pos),
    .data_byte (in_data_byte),
    .bit_len   ({total_r, 3'b000}),
    .rd_word   (msg_word)
  );

  md5_round_unit u_rnd (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (rc),
    .msg_word (msg_word),
    .chain    (chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5_pkg::ST_IDLE;
      fin_r   <= 1'b0;
      spill_r <= 1'b0;
      cnt_r   <= '0;
      rnd_r   <= '0;
      ph_r    <= 1'b0;
      idx_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      spill_r <= spill_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    fin_nxt     = fin_r;
    spill_nxt   = spill_r;
    cnt_nxt     = cnt_r;
    rnd_nxt     = rnd_r;
    ph_nxt      = ph_r;
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    rc          = '0;
    rc.rnd      = rnd_r;
    bc          = '0;
    bc.pad_addr = cnt_r;
    bc.second   = spill_r;
    case (state_r)
      md5_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == md5_pkg::FUNC_ABSORB) begin
            bc.byte_we = 1'b1;
            total_nxt  = total_r + 61'd1;
            if (pos == md5_pkg::LAST_POS) begin
              state_nxt = md5_pkg::ST_LOAD;
            end
          end else begin
            fin_nxt   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        bc.pad_we = 1'b1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == md5_pkg::LAST_WORD) begin
          state_nxt = md5_pkg::ST_LOAD;
        end
      end
      md5_pkg::ST_LOAD: begin
        rc.load   = 1'b1;
        rnd_nxt   = '0;
        ph_nxt    = 1'b0;
        state_nxt = md5_pkg::ST_RND;
      end
      md5_pkg::ST_RND: begin
        if (!ph_r) begin
          rc.sum_en = 1'b1;
          ph_nxt    = 1'b1;
        end else begin
          rc.step_en = 1'b1;
          ph_nxt     = 1'b0;
          rnd_nxt    = rnd_r + 6'd1;
          if (rnd_r == md5_pkg::LAST_ROUND) begin
            state_nxt = md5_pkg::ST_FOLD;
          end
        end
      end
      md5_pkg::ST_FOLD: begin
        rc.fold = 1'b1;
        if (!fin_r) begin
          state_nxt = md5_pkg::ST_IDLE;
        end else if (pos >= md5_pkg::LEN_POS && !spill_r) begin
          spill_nxt = 1'b1;
          cnt_nxt   = '0;
          state_nxt = md5_pkg::ST_PAD;
        end else begin
          idx_nxt   = '0;
          state_nxt = md5_pkg::ST_EMIT;
        end
      end
      md5_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == md5_pkg::LAST_IDX) begin
            rc.init   = 1'b1;
            total_nxt = '0;
            fin_nxt   = 1'b0;
            spill_nxt = 1'b0;
            state_nxt = md5_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = md5_pkg::ST_IDLE;
      end
    endcase
    // fetch the message word from the next round index, so the registered read matches rnd_r
    bc.rnd = rnd_nxt;
  end

  assign out_digest_word = chain[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == md5_pkg::LAST_IDX);

endmodule

FILE: rtl/core/md5_digest_checker.sv
module md5_digest_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [1:0]  out_word_index,
  input logic        out_last_word
);

  a_busy_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input taken while digest beats pending");

  a_words_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 2'd1)
    else $error("digest beat sequence broken");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid)
    else $error("beat after last digest word");

  a_absorb_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func |=> !out_valid)
    else $error("absorb produced a digest beat");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word))
    else $error("digest beat dropped or changed under stall");

endmodule

bind md5_digest_engine md5_digest_checker u_md5_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);
